// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BSST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BSST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSST_ASSERT(lbl, prop, msg)
`define BSST_ASSERT_IMPL(lbl, ante, cons, msg)
`define BSST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer slot status table package
// Sizes, action codes and the structures shared by the cells and the top level.
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int SLOTS = 8;
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int SIW   = 3;
  localparam int XW    = (IW > SIW) ? IW : SIW;

  typedef enum logic [2:0] {
    ActWrite    = 3'd0,
    ActFindHead = 3'd1,
    ActFindTail = 3'd2,
    ActCount    = 3'd3,
    ActFindId   = 3'd4,
    ActLowest   = 3'd5
  } bsst_action_e;

  // Request broadcast to every cell for the duration of one sweep.
  typedef struct packed {
    logic [2:0]    action;
    logic [2:0]    slot_index;
    logic [7:0]    status;
    logic [31:0]   id;
    logic [IW-1:0] start;
    logic [7:0]    free_code;
  } bsst_req_t;

  // Partial result handed from one cell to the next.
  typedef struct packed {
    logic          fh;    // hit at or after the start pointer
    logic [IW-1:0] ih;
    logic          fa;    // first hit anywhere
    logic [IW-1:0] ia;
    logic [CW-1:0] cnt;
    logic          fb;    // lowest id candidate held
    logic [IW-1:0] ib;
    logic [31:0]   best;
  } bsst_acc_t;

endpackage

// ===== hdl/buffer_slot_status_table.sv =====
// ----------------------------------------------------------------------------
// Buffer slot status table
// Slot table with circular search pointers, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Requests enter on a valid/ready channel (action_i, slot_index_i,
// status_code_i, block_id_i); each request gives exactly one result on a
// valid/ready output channel (found_o, slot_o, match_count_o).
// A request starts a token that walks the row of SLOTS cells, one cell per
// cycle; every cell folds its slot into the partial result and applies its
// own write or free as the token passes. The head and tail pointers are
// updated when the result is registered.
// A request passes start_q, the row of cells and fin_q before its result is
// registered at out_valid_o. One request is in flight at a time, so a new
// request is taken only once the previous result has been registered; the
// walk through the cell row sets the pace.
// A finished result waits in the output register; if the receiver stalls
// while a second request completes, that result holds at the end of the row
// until the output register is free.
// free_code is written through cfg_we_i/cfg_wdata_i with no wait state.
// Reset clears every slot to status 0, id 0 and both pointers to 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buffer_slot_status_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  slot_index_i,
  input  logic [7:0]  status_code_i,
  input  logic [31:0] block_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [2:0]  slot_o,
  output logic [3:0]  match_count_o
);
  import bsst_pkg::*;

  logic          busy_q;
  logic          start_q;
  logic          fin_q;
  bsst_acc_t     fin_acc_q;
  bsst_req_t     req_q;
  logic [7:0]    free_code_q;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic          out_valid_q, found_q;
  logic [2:0]    slot_q;
  logic [3:0]    count_q;

  logic          tok [0:SLOTS];
  bsst_acc_t     acc [0:SLOTS];
  logic [SLOTS+1:0] tok_vec;

  logic          accept, retire;
  logic          res_found;
  logic [IW-1:0] res_slot, next_slot;

  assign accept = in_valid_i && in_ready_o;
  assign retire = fin_q && (!out_valid_q || out_ready_i);

  assign tok[0] = start_q;
  assign acc[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    bsst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IW'(k)),
      .req_i      (req_q),
      .token_i    (tok[k]),
      .acc_i      (acc[k]),
      .token_o    (tok[k+1]),
      .acc_o      (acc[k+1])
    );
  end

  always_comb begin
    res_found = 1'b0;
    res_slot  = '0;
    unique case (req_q.action)
      ActFindHead, ActFindTail: begin
        res_found = fin_acc_q.fh || fin_acc_q.fa;
        res_slot  = fin_acc_q.fh ? fin_acc_q.ih : fin_acc_q.ia;
      end
      ActFindId: begin
        res_found = fin_acc_q.fa;
        res_slot  = fin_acc_q.ia;
      end
      ActLowest: begin
        res_found = fin_acc_q.fb;
        res_slot  = fin_acc_q.ib;
      end
      default: begin
        res_found = 1'b0;
        res_slot  = '0;
      end
    endcase
    if (!res_found) begin
      res_slot = '0;
    end
    next_slot = (res_slot == IW'(SLOTS - 1)) ? '0 : res_slot + IW'(1);
    head_d = head_q;
    tail_d = tail_q;
    if (res_found && req_q.action == ActFindHead) begin
      head_d = next_slot;
    end
    if (res_found && (req_q.action == ActFindTail || req_q.action == ActLowest)) begin
      tail_d = next_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      free_code_q <= 8'd0;
    end else begin
      start_q <= accept;
      if (cfg_we_i) begin
        free_code_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (retire) begin
        busy_q <= 1'b0;
      end
      if (tok[SLOTS]) begin
        fin_q <= 1'b1;
      end else if (retire) begin
        fin_q <= 1'b0;
      end
      if (retire) begin
        out_valid_q <= 1'b1;
        head_q      <= head_d;
        tail_q      <= tail_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.action     <= action_i;
      req_q.slot_index <= slot_index_i;
      req_q.status     <= status_code_i;
      req_q.id         <= block_id_i;
      req_q.start      <= (action_i == ActFindTail) ? tail_q : head_q;
      req_q.free_code  <= free_code_q;
    end
    if (tok[SLOTS]) begin
      fin_acc_q <= acc[SLOTS];
    end
    if (retire) begin
      found_q <= res_found;
      slot_q  <= 3'(res_slot);
      count_q <= (req_q.action == ActCount) ? 4'(fin_acc_q.cnt) : 4'd0;
    end
  end

  assign in_ready_o    = !busy_q;
  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign slot_o        = slot_q;
  assign match_count_o = count_q;

  always_comb begin
    tok_vec[0] = start_q;
    for (int k = 1; k <= SLOTS; k++) begin
      tok_vec[k] = tok[k];
    end
    tok_vec[SLOTS+1] = fin_q;
  end

  // Only one request may be in the cell row or waiting at its end.
  `BSST_ASSERT(a_one_token, $onehot0(tok_vec), "more than one token in the cell row")
  `BSST_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "request taken while busy")
  `BSST_ASSERT_IMPL(a_slot_zero_on_miss, out_valid_o && !found_o, slot_o == 3'd0,
                    "slot not zero on a miss")

endmodule

// ===== hdl/bsst_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot's status and id, folds its slot into the passing partial
// result and performs the slot's own write or free when the token visits.
// ----------------------------------------------------------------------------
module bsst_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [bsst_pkg::IW-1:0] cell_idx_i,
  input  bsst_pkg::bsst_req_t   req_i,
  input  logic                  token_i,
  input  bsst_pkg::bsst_acc_t   acc_i,
  output logic                  token_o,
  output bsst_pkg::bsst_acc_t   acc_o
);
  import bsst_pkg::*;

  logic [7:0]  status_q, status_d;
  logic [31:0] id_q, id_d;
  logic        token_q;
  bsst_acc_t   acc_q, acc_d;
  logic        st_hit, id_eq, id_lt, best_lt, hit;

  always_comb begin
    st_hit  = (status_q == req_i.status);
    id_eq   = (id_q == req_i.id);
    id_lt   = (id_q < req_i.id);
    best_lt = (id_q < acc_i.best);
    acc_d   = acc_i;
    status_d = status_q;
    id_d     = id_q;

    unique case (req_i.action)
      ActFindHead, ActFindTail: hit = st_hit;
      ActFindId:                hit = st_hit && id_eq && (req_i.id != 32'd0);
      default:                  hit = 1'b0;
    endcase

    if (hit) begin
      if (!acc_i.fa) begin
        acc_d.fa = 1'b1;
        acc_d.ia = cell_idx_i;
      end
      if (!acc_i.fh && (cell_idx_i >= req_i.start)) begin
        acc_d.fh = 1'b1;
        acc_d.ih = cell_idx_i;
      end
    end

    if ((req_i.action == ActCount) && st_hit) begin
      acc_d.cnt = acc_i.cnt + CW'(1);
    end

    if (req_i.action == ActLowest && st_hit) begin
      if (id_lt) begin
        // Slots below the threshold are released as the sweep passes.
        status_d = req_i.free_code;
      end else if (!acc_i.fb || best_lt) begin
        acc_d.fb   = 1'b1;
        acc_d.ib   = cell_idx_i;
        acc_d.best = id_q;
      end
    end

    if (req_i.action == ActWrite &&
        XW'(req_i.slot_index) == XW'(cell_idx_i)) begin
      status_d = req_i.status;
      id_d     = req_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 8'd0;
      id_q     <= 32'd0;
      token_q  <= 1'b0;
    end else begin
      token_q <= token_i;
      if (token_i) begin
        status_q <= status_d;
        id_q     <= id_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (token_i) begin
      acc_q <= acc_d;
    end
  end

  assign token_o = token_q;
  assign acc_o   = acc_q;

endmodule
